// ===== sv/miller_rabin_witness_test_macros.svh =====
// assertion macros shared by the miller-rabin witness test rtl
`ifndef MILLER_RABIN_WITNESS_TEST_MACROS_SVH
`define MILLER_RABIN_WITNESS_TEST_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define MRW_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// condition in one cycle implies a condition in the next cycle
`define MRW_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define MRW_ASSERT(label, prop)
`define MRW_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== sv/mrw_pkg.sv =====
// shared constants, types and state encoding of the miller-rabin witness test
package mrw_pkg;

  localparam int NUM_BITS = 62;
  localparam int IDX_W    = $clog2(NUM_BITS);

  typedef logic [NUM_BITS-1:0] word_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [1:0]          verdict_t;

  localparam verdict_t VERDICT_COMPOSITE = 2'd0;
  localparam verdict_t VERDICT_PRIME     = 2'd1;
  localparam verdict_t VERDICT_BAD_BASE  = 2'd2;

  // request to the modular multiplier
  typedef struct packed {
    logic  start;
    word_t opa;
    word_t opb;
    word_t modulus;
  } mrw_mul_req_t;

  // response from the modular multiplier
  typedef struct packed {
    logic  done;
    word_t prod;
  } mrw_mul_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_CHECK,
    ST_RSQ_GO,
    ST_RSQ_WAIT,
    ST_FINISH
  } mrw_state_t;

endpackage

// ===== sv/mrw_modmul.sv =====
// shift-and-add modular multiplier, one multiplier bit per cycle
`include "miller_rabin_witness_test_macros.svh"
module mrw_modmul
  import mrw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  mrw_mul_req_t req,
  output mrw_mul_rsp_t rsp
);

  logic  busy;
  logic  done;
  idx_t  cnt;
  word_t acc;
  word_t acc_next;
  word_t xr;
  word_t yr;
  word_t m;

  logic [NUM_BITS:0]   dbl;
  logic [NUM_BITS:0]   dbl_sub;
  word_t               half;
  logic [NUM_BITS:0]   sum;
  logic [NUM_BITS:0]   sum_sub;
  word_t               sum_red;

  // one step: double mod m, then add x mod m when the multiplier bit is set
  always_comb begin
    dbl     = {acc, 1'b0};
    dbl_sub = dbl - {1'b0, m};
    half    = (dbl >= {1'b0, m}) ? dbl_sub[NUM_BITS-1:0] : dbl[NUM_BITS-1:0];
    sum     = {1'b0, half} + {1'b0, xr};
    sum_sub = sum - {1'b0, m};
    sum_red = (sum >= {1'b0, m}) ? sum_sub[NUM_BITS-1:0] : sum[NUM_BITS-1:0];
    acc_next = yr[NUM_BITS-1] ? sum_red : half;
  end

  // control: busy while the NUM_BITS multiplier bits are stepped through, then a done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= IDX_W'(NUM_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operand and accumulator registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= '0;
      xr  <= req.opa;
      yr  <= req.opb;
      m   <= req.modulus;
    end else if (busy) begin
      acc <= acc_next;
      yr  <= {yr[NUM_BITS-2:0], 1'b0};
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

  `MRW_ASSERT(a_done_not_busy, !(done && busy))
  `MRW_ASSERT(a_no_start_busy, !(req.start && busy))
  `MRW_ASSERT_NEXT(a_last_step_done, busy && cnt == '0 && !req.start, done)

endmodule

// ===== sv/miller_rabin_witness_test.sv =====
// miller-rabin witness test top level: sequencer around one modular multiplier
//
// One strong-probable-prime round per item. An input transfer (in_valid and
// in_ready high) carries candidate and witness; one output transfer (out_valid
// and out_ready high) carries verdict: 0 composite, 1 probable prime, 2 witness
// outside 2..candidate-2. Candidates 0 and 1 are composite, 2 and 3 prime.
// in_ready is high only while the sequencer is idle; one item at a time.
// Tiny candidates, bad witnesses and even candidates go from idle straight to finish.
// Otherwise candidate-1 is split into d*2^s at one bit per cycle, then
// witness^d mod candidate takes 62 squarings and one product per set bit of
// d, and up to s-1 more squarings follow. Each product runs on the shared
// shift-and-add multiplier, one bit per cycle, started from a GO state and
// collected in the matching WAIT state.
// The result sits in an output register; a new item is taken while it waits.
// If the receiver stalls, a finished verdict waits in the sequencer until the
// output register frees, then the block returns to idle.
// Reset (rst, synchronous) returns to idle with no result pending.
`include "miller_rabin_witness_test_macros.svh"
module miller_rabin_witness_test
  import mrw_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [NUM_BITS-1:0] candidate,
  input  logic [NUM_BITS-1:0] witness,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    verdict
);

  mrw_state_t   state;
  mrw_state_t   state_next;
  mrw_mul_req_t mul_req;
  mrw_mul_rsp_t mul_rsp;

  word_t    n;
  word_t    nm1;
  word_t    a;
  word_t    d;
  word_t    r;
  idx_t     s;
  idx_t     i;
  idx_t     k;
  verdict_t res_code;

  logic     accept;
  logic     out_free;
  word_t    cand_m1;
  word_t    cand_m2;
  logic     tiny_comp;
  logic     tiny_prime;
  logic     bad_base;
  logic     even_cand;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // quick classification of the incoming item
  always_comb begin
    cand_m1    = candidate - 1'b1;
    cand_m2    = candidate - 2'd2;
    tiny_comp  = (candidate <= NUM_BITS'(1));
    tiny_prime = (candidate <= NUM_BITS'(3));
    bad_base   = (witness < NUM_BITS'(2)) || (witness > cand_m2);
    even_cand  = !candidate[0];
  end

  // shared modular multiplier
  mrw_modmul u_modmul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and multiplier requests
  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    mul_req.start   = 1'b0;
    mul_req.opa     = r;
    mul_req.opb     = r;
    mul_req.modulus = n;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (tiny_comp || tiny_prime || bad_base || even_cand) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_SPLIT;
          end
        end
      end
      ST_SPLIT: begin
        if (d[0]) begin
          state_next = ST_SQ_GO;
        end
      end
      ST_SQ_GO: begin
        mul_req.start = 1'b1;
        state_next    = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (mul_rsp.done) begin
          if (d[i]) begin
            state_next = ST_MUL_GO;
          end else if (i == '0) begin
            state_next = ST_CHECK;
          end else begin
            state_next = ST_SQ_GO;
          end
        end
      end
      ST_MUL_GO: begin
        mul_req.start = 1'b1;
        mul_req.opb   = a;
        state_next    = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_rsp.done) begin
          state_next = (i == '0) ? ST_CHECK : ST_SQ_GO;
        end
      end
      ST_CHECK: begin
        if (r == NUM_BITS'(1) || r == nm1 || s < IDX_W'(2)) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_RSQ_GO;
        end
      end
      ST_RSQ_GO: begin
        mul_req.start = 1'b1;
        state_next    = ST_RSQ_WAIT;
      end
      ST_RSQ_WAIT: begin
        if (mul_rsp.done) begin
          if (mul_rsp.prod == NUM_BITS'(1) || mul_rsp.prod == nm1 || k == IDX_W'(1)) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_RSQ_GO;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath registers of the sequencer
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        n   <= candidate;
        a   <= witness;
        nm1 <= cand_m1;
        d   <= cand_m1;
        s   <= '0;
        if (tiny_comp) begin
          res_code <= VERDICT_COMPOSITE;
        end else if (tiny_prime) begin
          res_code <= VERDICT_PRIME;
        end else if (bad_base) begin
          res_code <= VERDICT_BAD_BASE;
        end else begin
          res_code <= VERDICT_COMPOSITE;
        end
      end
      ST_SPLIT: begin
        if (!d[0]) begin
          d <= {1'b0, d[NUM_BITS-1:1]};
          s <= s + 1'b1;
        end else begin
          r <= NUM_BITS'(1);
          i <= IDX_W'(NUM_BITS - 1);
        end
      end
      ST_SQ_WAIT: begin
        if (mul_rsp.done) begin
          r <= mul_rsp.prod;
          if (!d[i] && i != '0) begin
            i <= i - 1'b1;
          end
        end
      end
      ST_MUL_WAIT: begin
        if (mul_rsp.done) begin
          r <= mul_rsp.prod;
          if (i != '0) begin
            i <= i - 1'b1;
          end
        end
      end
      ST_CHECK: begin
        k <= s - 1'b1;
        if (r == NUM_BITS'(1) || r == nm1) begin
          res_code <= VERDICT_PRIME;
        end else begin
          res_code <= VERDICT_COMPOSITE;
        end
      end
      ST_RSQ_WAIT: begin
        if (mul_rsp.done) begin
          r <= mul_rsp.prod;
          k <= k - 1'b1;
          if (mul_rsp.prod == nm1 && mul_rsp.prod != NUM_BITS'(1)) begin
            res_code <= VERDICT_PRIME;
          end else begin
            res_code <= VERDICT_COMPOSITE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      verdict <= res_code;
    end
  end

  `MRW_ASSERT(a_done_in_wait, !mul_rsp.done || state == ST_SQ_WAIT ||
    state == ST_MUL_WAIT || state == ST_RSQ_WAIT)
  `MRW_ASSERT_NEXT(a_accept_leaves_idle, accept, state != ST_IDLE)
  `MRW_ASSERT(a_split_nonzero, state != ST_SPLIT || d != '0)
  `MRW_ASSERT_NEXT(a_finish_loads_out, state == ST_FINISH && out_free, out_valid)

endmodule

// ===== test/tb_miller_rabin_witness_test.sv =====
`timescale 1ns / 1ps
// testbench for the miller-rabin witness test: directed table, then random rounds
module tb_miller_rabin_witness_test;
  import mrw_pkg::*;

  localparam int    HALF_PERIOD   = 6;
  localparam int    RESET_CYCLES  = 12;
  localparam int    RANDOM_ITEMS  = 80;
  localparam int    IDLE_PCT      = 27;
  localparam int    STALL_LIMIT   = 50000;
  localparam int    DRAIN_CYCLES  = 200;
  localparam int    NOTABLE_COUNT = 14;
  localparam word_t ALL_ONES      = '1;

  // one round: operands and the verdict it must produce
  typedef struct packed {
    word_t    cand;
    word_t    wit;
    verdict_t want;
  } round_t;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     out_ready = 1'b0;
  word_t    candidate = '0;
  word_t    witness   = '0;
  logic     in_ready;
  logic     out_valid;
  verdict_t verdict;

  round_t table_rows[$];
  round_t rounds_due[$];
  int     mismatches   = 0;
  int     quiet_cycles = 0;
  bit     steady       = 1'b0;

  miller_rabin_witness_test DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .candidate (candidate),
    .witness   (witness),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .verdict   (verdict)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // (x + y) mod m with x, y below m
  function automatic logic [63:0] sum_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [63:0] t;
    t = x + y;
    if (t >= m) t = t - m;
    return t;
  endfunction

  // shift-and-add product mod m, multiplier scanned from its top bit
  function automatic logic [63:0] product_mod(logic [63:0] x, logic [63:0] y,
                                              logic [63:0] m);
    logic [63:0] acc;
    acc = '0;
    for (int i = NUM_BITS - 1; i >= 0; i--) begin
      acc = sum_mod(acc, acc, m);
      if (y[i]) acc = sum_mod(acc, x, m);
    end
    return acc;
  endfunction

  // square-and-multiply power mod m
  function automatic logic [63:0] power_mod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] r;
    r = 64'd1 % m;
    for (int i = NUM_BITS - 1; i >= 0; i--) begin
      r = product_mod(r, r, m);
      if (e[i]) r = product_mod(r, b, m);
    end
    return r;
  endfunction

  // full verdict of one strong-probable-prime round
  function automatic verdict_t round_verdict(word_t cand, word_t wit);
    logic [63:0] n;
    logic [63:0] a;
    logic [63:0] d;
    logic [63:0] x;
    int          s;
    n = {2'b00, cand};
    a = {2'b00, wit};
    if (n <= 64'd1) return VERDICT_COMPOSITE;
    if (n <= 64'd3) return VERDICT_PRIME;
    if (a < 64'd2 || a > n - 64'd2) return VERDICT_BAD_BASE;
    if (!n[0]) return VERDICT_COMPOSITE;
    // split n-1 into d * 2^s
    d = n - 64'd1;
    s = 0;
    while (!d[0] && d != '0) begin
      d = d >> 1;
      s++;
    end
    x = power_mod(a, d, n);
    if (x == 64'd1 || x == n - 64'd1) return VERDICT_PRIME;
    for (int r = 1; r < s; r++) begin
      x = product_mod(x, x, n);
      if (x == 64'd1) return VERDICT_COMPOSITE;
      if (x == n - 64'd1) return VERDICT_PRIME;
    end
    return VERDICT_COMPOSITE;
  endfunction

  function automatic word_t rand_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[NUM_BITS-1:0];
  endfunction

  // odd candidate of random length, at least 5
  function automatic word_t rand_odd();
    word_t r;
    r = rand_word() >> $urandom_range(0, NUM_BITS - 4);
    r[0] = 1'b1;
    if (r < word_t'(5)) r = word_t'(5);
    return r;
  endfunction

  // witness in 2..n-2, n at least 4
  function automatic word_t pick_witness(word_t n);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return word_t'(64'd2 + r % ({2'b00, n} - 64'd3));
  endfunction

  // primes and strong pseudoprimes worth hitting often
  function automatic word_t notable_number(int k);
    case (k)
      0:       return 62'd5;
      1:       return 62'd7;
      2:       return 62'd97;
      3:       return 62'd65537;
      4:       return 62'd2147483647;
      5:       return 62'd1000000007;
      6:       return 62'd998244353;
      7:       return 62'd2305843009213693951;
      8:       return 62'd4611686018427387847;
      9:       return 62'd2047;
      10:      return 62'd561;
      11:      return 62'd1373653;
      12:      return 62'd25326001;
      default: return 62'd3215031751;
    endcase
  endfunction

  task automatic add_known(input word_t c, input word_t w, input verdict_t v);
    round_t row;
    row.cand = c;
    row.wit  = w;
    row.want = v;
    table_rows.push_back(row);
  endtask

  task automatic add_checked(input word_t c, input word_t w);
    add_known(c, w, round_verdict(c, w));
  endtask

  task automatic note_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // random sender gap, skipped in the steady stretch
  task automatic pace_sender();
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
  endtask

  // present one round and hold it until the input transfer
  task automatic offer(input word_t c, input word_t w, input verdict_t want);
    round_t due;
    due.cand = c;
    due.wit  = w;
    due.want = want;
    in_valid  <= 1'b1;
    candidate <= c;
    witness   <= w;
    do @(posedge clk); while (!in_ready);
    rounds_due.push_back(due);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // verdict check against the oldest pending round
  always @(posedge clk) begin
    round_t due;
    if (!rst && out_valid && out_ready) begin
      if (rounds_due.size() == 0) begin
        note_mismatch($sformatf("verdict %0d with no round pending", verdict));
      end else begin
        due = rounds_due.pop_front();
        if (verdict !== due.want)
          note_mismatch($sformatf("candidate %0d witness %0d: verdict %0d, want %0d",
                                  due.cand, due.wit, verdict, due.want));
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    word_t c;
    word_t w;
    int    kind;

    // tiny candidates, witness bounds, even candidates
    add_known(0, 0, VERDICT_COMPOSITE);
    add_known(1, ALL_ONES, VERDICT_COMPOSITE);
    add_known(2, 0, VERDICT_PRIME);
    add_known(3, ALL_ONES, VERDICT_PRIME);
    add_known(4, 1, VERDICT_BAD_BASE);
    add_known(4, 3, VERDICT_BAD_BASE);
    add_known(4, 2, VERDICT_COMPOSITE);
    add_known(ALL_ONES - 1, 2, VERDICT_COMPOSITE);
    add_known(5, 4, VERDICT_BAD_BASE);
    add_known(9, 0, VERDICT_BAD_BASE);
    add_known(9, ALL_ONES, VERDICT_BAD_BASE);
    add_known(ALL_ONES, ALL_ONES - 1, VERDICT_BAD_BASE);
    // full rounds: small and widest candidates, primes, pseudoprimes
    add_checked(5, 2);
    add_checked(5, 3);
    add_checked(9, 7);
    add_checked(ALL_ONES, 2);
    add_checked(ALL_ONES, ALL_ONES - 2);
    add_checked(62'd2305843009213693951, 2);
    add_checked(62'd4611686018427387847, 3);
    add_checked(2047, 2);
    add_checked(2047, 3);
    add_checked(561, 2);
    add_checked(62'd3215031751, 7);
    add_checked(1373653, 2);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (table_rows[i]) begin
      pace_sender();
      offer(table_rows[i].cand, table_rows[i].wit, table_rows[i].want);
    end

    // hold off until every pending verdict has come back
    in_valid <= 1'b0;
    do @(posedge clk); while (rounds_due.size() != 0);

    // random rounds, mostly well-formed odd candidates with valid witnesses
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 40 && i < 65);
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        c = notable_number($urandom_range(0, NOTABLE_COUNT - 1));
        w = pick_witness(c);
      end else if (kind < 70) begin
        c = rand_odd();
        w = pick_witness(c);
      end else if (kind < 80) begin
        c = rand_word();
        w = rand_word();
      end else if (kind < 87) begin
        c = word_t'($urandom_range(0, 3));
        w = rand_word();
      end else if (kind < 94) begin
        c = rand_odd();
        c[0] = 1'b0;
        w = pick_witness(c);
      end else begin
        c = rand_odd();
        case ($urandom_range(0, 2))
          0:       w = word_t'($urandom_range(0, 1));
          1:       w = c - 1;
          default: w = rand_word() | c;
        endcase
      end
      pace_sender();
      offer(c, w, round_verdict(c, w));
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (rounds_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
